[hw/rtl/fpr_pkg.sv]
`timescale 1ns / 1ps
// fpr_pkg: types, character codes and limits shared by the passive reply parser
// no dependencies

package fpr_pkg;

   // reply character codes
   localparam logic [7:0] CharOpen  = 8'h28;
   localparam logic [7:0] CharClose = 8'h29;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharPipe  = 8'h7C;

   // field limits
   localparam logic [2:0]  PasvFields = 3'd6;
   localparam logic [2:0]  EpsvPipes  = 3'd3;
   localparam logic [2:0]  AddrFields = 3'd4;
   localparam logic [16:0] AccSat     = 17'd65536;
   localparam logic [16:0] OctetMax   = 17'd255;
   localparam logic [16:0] PortMax    = 17'd65535;

   // reply kinds
   localparam logic KindPasv = 1'b0;
   localparam logic KindEpsv = 1'b1;

   // result status codes
   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusMissing = 2'd1;
   localparam logic [1:0] StatusRange   = 2'd2;

   // configuration port
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic CsrIdxReplyKind = 1'b0;

   typedef enum logic [1:0] {
      PhaseSeek,
      PhaseBody,
      PhaseDone
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  field_count;
      logic        field_open;
      logic        digits_started;
      logic        digits_ended;
      logic [16:0] accumulator;
      logic        range_error;
      logic [31:0] address_store;
      logic [7:0]  port_high;
   } parse_state_type;

   typedef struct packed {
      logic [31:0] host_address;
      logic [15:0] data_port;
      logic [1:0]  parse_status;
   } result_type;

   localparam parse_state_type StateClear = '{
      phase:          PhaseSeek,
      field_count:    3'd0,
      field_open:     1'b0,
      digits_started: 1'b0,
      digits_ended:   1'b0,
      accumulator:    17'd0,
      range_error:    1'b0,
      address_store:  32'd0,
      port_high:      8'd0
   };

endpackage

[hw/rtl/fpr_csr.sv]
`timescale 1ns / 1ps
// fpr_csr: apb-style register port holding the reply kind select
// depends on fpr_pkg

module fpr_csr
   import fpr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output logic                    reply_kind
);

   logic reply_kind_ff;
   logic reply_kind_in;
   logic write_hit;
   logic reg_index;

   // word index; byte offset bits are ignored
   assign reg_index = csr_paddr[CsrAddrWidth-1];
   assign write_hit = csr_psel && csr_penable && csr_pwrite && (reg_index == CsrIdxReplyKind);
   assign reply_kind_in = write_hit ? csr_pwdata[0] : reply_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_kind_ff <= KindPasv;
      end else begin
         reply_kind_ff <= reply_kind_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (reg_index == CsrIdxReplyKind) ?
                       {{(CsrDataWidth-1){1'b0}}, reply_kind_ff} : '0;
   assign reply_kind = reply_kind_ff;

endmodule

[hw/rtl/fpr_step.sv]
`timescale 1ns / 1ps
// fpr_step: next-state and result logic for one reply byte
// depends on fpr_pkg

module fpr_step
   import fpr_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      char_byte,
   input  logic            first_byte,
   input  logic            final_byte,
   input  logic            reply_kind,
   output parse_state_type next_state,
   output logic            emit,
   output result_type      result
);

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic parse_state_type feed_digit(input parse_state_type s,
                                                  input logic [7:0] c);
      parse_state_type r;
      logic [19:0]     prod;
      r = s;
      // acc*10 + digit, acc never exceeds 65536 so 20 bits hold it
      prod = ({3'b000, s.accumulator} << 3) + ({3'b000, s.accumulator} << 1) +
             {16'd0, c[3:0]};
      if (!s.digits_ended) begin
         if ((c >= 8'h30) && (c <= 8'h39)) begin
            r.digits_started = 1'b1;
            r.accumulator = (prod > {3'b000, AccSat}) ? AccSat : prod[16:0];
         end else if (!(is_space(c) && !s.digits_started)) begin
            r.digits_ended = 1'b1;
         end
      end
      return r;
   endfunction

   // the sixth value stays in the accumulator
   function automatic parse_state_type commit_field(input parse_state_type s);
      parse_state_type r;
      r = s;
      if (s.field_count < PasvFields) begin
         if (s.accumulator > OctetMax) begin
            r.range_error = 1'b1;
         end
         if (s.field_count < AddrFields) begin
            r.address_store = {s.address_store[23:0], s.accumulator[7:0]};
         end else if (s.field_count == AddrFields) begin
            r.port_high = s.accumulator[7:0];
         end
         r.field_count = s.field_count + 3'd1;
         r.field_open = 1'b0;
         if (r.field_count < PasvFields) begin
            r.accumulator = 17'd0;
            r.digits_started = 1'b0;
            r.digits_ended = 1'b0;
         end
      end
      return r;
   endfunction

   parse_state_type s0;
   parse_state_type s1;
   parse_state_type s2;
   parse_state_type s_fin;
   logic            close;

   always_comb begin
      s0 = first_byte ? StateClear : cur_state;
      s1 = s0;
      close = 1'b0;
      case (s0.phase)
         PhaseSeek: begin
            if (char_byte == CharOpen) begin
               s1.phase = PhaseBody;
            end
         end
         PhaseBody: begin
            if (reply_kind == KindPasv) begin
               if (char_byte == CharClose) begin
                  close = 1'b1;
               end else if (s0.field_count < PasvFields) begin
                  if (char_byte == CharComma) begin
                     if (s0.field_open) begin
                        s1 = commit_field(s0);
                     end
                  end else begin
                     s1 = feed_digit(s0, char_byte);
                     s1.field_open = 1'b1;
                  end
               end
            end else begin
               if (char_byte == CharClose) begin
                  close = 1'b1;
               end else if (char_byte == CharPipe) begin
                  if (s0.field_count < EpsvPipes) begin
                     s1.field_count = s0.field_count + 3'd1;
                  end else begin
                     close = 1'b1;
                  end
               end else if (s0.field_count >= EpsvPipes) begin
                  s1 = feed_digit(s0, char_byte);
               end
            end
         end
         default: begin
         end
      endcase

      emit = close || (final_byte && (s1.phase != PhaseDone));

      // judge the reply; an open field is taken as if it had been closed
      s2 = s1;
      result = '{host_address: 32'd0, data_port: 16'd0, parse_status: StatusMissing};
      if (s1.phase == PhaseBody) begin
         if (reply_kind == KindPasv) begin
            if (s1.field_open && (s1.field_count < PasvFields)) begin
               s2 = commit_field(s1);
            end
            if (s2.field_count >= PasvFields) begin
               if (s2.range_error) begin
                  result.parse_status = StatusRange;
               end else begin
                  result.parse_status = StatusOk;
                  result.host_address = s2.address_store;
                  result.data_port = {s2.port_high, s2.accumulator[7:0]};
               end
            end
         end else if (s1.field_count >= EpsvPipes) begin
            if (s1.accumulator > PortMax) begin
               result.parse_status = StatusRange;
            end else begin
               result.parse_status = StatusOk;
               result.data_port = s1.accumulator[15:0];
            end
         end
      end

      s_fin = s2;
      s_fin.phase = PhaseDone;
      next_state = emit ? s_fin : s1;
   end

endmodule

[hw/rtl/ftp_passive_reply_parser.sv]
`timescale 1ns / 1ps
// ftp_passive_reply_parser: top level of the pasv/epsv reply parser
// depends on fpr_pkg, fpr_csr, fpr_step
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     char_byte, first_byte, final_byte
//   rsp      out        rsp_valid / rsp_ready     host_address, data_port, parse_status
//   csr      in         csr_psel/penable/pready   reply_kind at word 0
//
// one byte per cycle; each byte is parsed in the cycle it is taken and updates the
// parse state register; a reply's result lands in the output register the cycle after
// its closing byte. reset is synchronous and clears parse state and reply_kind.
// req_ready drops only while a result waits in the output register and rsp_ready is low.

module ftp_passive_reply_parser
   import fpr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_char_byte,
   input  logic                    req_first_byte,
   input  logic                    req_final_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             rsp_host_address,
   output logic [15:0]             rsp_data_port,
   output logic [1:0]              rsp_parse_status,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic            reply_kind;
   logic            req_xfer;
   logic            emit;
   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_in;
   result_type      result_ff;
   logic            rsp_valid_ff;

   fpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .reply_kind  (reply_kind)
   );

   fpr_step u_step (
      .cur_state  (state_ff),
      .char_byte  (req_char_byte),
      .first_byte (req_first_byte),
      .final_byte (req_final_byte),
      .reply_kind (reply_kind),
      .next_state (state_in),
      .emit       (emit),
      .result     (result_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateClear;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         if (req_xfer && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded only when a reply closes
   always_ff @(posedge clock) begin
      if (req_xfer && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_host_address = result_ff.host_address;
   assign rsp_data_port    = result_ff.data_port;
   assign rsp_parse_status = result_ff.parse_status;

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !req_xfer |=> !rsp_valid_ff)
      else $error("result register kept valid after its transfer");

   a_fail_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result_ff.parse_status != StatusOk) |->
         (result_ff.host_address == 32'd0) && (result_ff.data_port == 16'd0))
      else $error("failed parse carries address or port");

   a_field_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.field_count <= PasvFields)
      else $error("field count beyond six");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.accumulator <= AccSat)
      else $error("accumulator beyond saturation value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.parse_status == StatusOk) ||
         (result_ff.parse_status == StatusMissing) || (result_ff.parse_status == StatusRange))
      else $error("undefined parse status");

endmodule
